// ----- rtl/sixu_pkg.sv -----
// shared widths and queue entry type for the six-axis unit vector block
package sixu_pkg;

  localparam int MAX_AXES   = 6;
  localparam int COORD_W    = 32;
  localparam int MAG_W      = 32;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int SUM_W      = 67;
  localparam int RAD_W      = 68;
  localparam int LEN_W      = 34;
  localparam int QUO_W      = 31;
  localparam int UNIT_W     = 32;
  localparam int SQ_REM_W   = 38;
  localparam int STEP_W     = 3;
  localparam int CNT_W      = 6;
  localparam int SQRT_STEPS = 34;
  localparam int DIV_STEPS  = 31;

  typedef struct packed {
    logic [MAX_AXES-1:0][MAG_W-1:0] mag;
    logic [MAX_AXES-1:0]            neg;
    logic [SUM_W-1:0]               sum;
  } item_t;

endpackage

// ----- rtl/sixu_front.sv -----
// front end: takes a request, forms the differences and sums their squares
module sixu_front #(
  parameter int AXIS_COUNT = 6
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  logic                                                in_valid,
  output logic                                                in_ready,
  input  logic [sixu_pkg::MAX_AXES-1:0][sixu_pkg::COORD_W-1:0] target,
  input  logic [sixu_pkg::MAX_AXES-1:0][sixu_pkg::COORD_W-1:0] position,
  output logic                                                push_valid,
  input  logic                                                push_ready,
  output sixu_pkg::item_t                                     push_item
);
  import sixu_pkg::*;

  logic                             busy;
  logic [STEP_W-1:0]                step;
  logic [MAX_AXES-1:0][MAG_W-1:0]   mag;
  logic [MAX_AXES-1:0]              neg;
  logic [SUM_W-1:0]                 sum;
  logic [SQ_W-1:0]                  prod;

  logic [MAX_AXES-1:0][COORD_W:0]   diff;
  logic [MAX_AXES-1:0][COORD_W:0]   absd;
  logic [MAX_AXES-1:0][MAG_W-1:0]   new_mag;
  logic [MAX_AXES-1:0]              new_neg;
  logic [MAG_W-1:0]                 cur;
  logic [SQ_W-1:0]                  sq;
  logic                             finish;
  logic                             accept;

  always_comb begin
    for (int a = 0; a < MAX_AXES; a++) begin
      diff[a] = {target[a][COORD_W-1], target[a]} - {position[a][COORD_W-1], position[a]};
      absd[a] = diff[a][COORD_W] ? (~diff[a] + 1'b1) : diff[a];
      if (a < AXIS_COUNT) begin
        new_mag[a] = absd[a][MAG_W-1:0];
        new_neg[a] = diff[a][COORD_W];
      end else begin
        new_mag[a] = '0;
        new_neg[a] = 1'b0;
      end
    end
  end

  // one square per cycle, registered and accumulated in the following cycle
  assign cur    = (step < STEP_W'(AXIS_COUNT)) ? mag[step] : '0;
  assign sq     = cur * cur;
  assign finish = busy && (step == STEP_W'(AXIS_COUNT + 1));
  assign in_ready   = !busy || (finish && push_ready);
  assign accept     = in_valid && in_ready;
  assign push_valid = finish;

  assign push_item.mag = mag;
  assign push_item.neg = neg;
  assign push_item.sum = sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (accept) begin
      busy <= 1'b1;
      step <= '0;
    end else if (finish && push_ready) begin
      busy <= 1'b0;
    end else if (busy && !finish) begin
      step <= step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mag  <= new_mag;
      neg  <= new_neg;
      sum  <= '0;
      prod <= '0;
    end else if (busy && !finish) begin
      prod <= sq;
      sum  <= sum + SUM_W'(prod);
    end
  end

endmodule

// ----- rtl/sixu_queue.sv -----
// two-entry request queue between front and back
module sixu_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  sixu_pkg::item_t wr_item,
  output logic            rd_valid,
  input  logic            rd_ready,
  output sixu_pkg::item_t rd_item
);
  import sixu_pkg::*;

  item_t       slot [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  logic        pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_item  = slot[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop)      count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= wr_item;
  end

endmodule

// ----- rtl/sixu_back.sv -----
// back end: bit-serial square root, six parallel bit-serial dividers, output register
module sixu_back (
  input  logic                                               clk,
  input  logic                                               rst,
  input  logic                                               pop_valid,
  output logic                                               pop_ready,
  input  sixu_pkg::item_t                                    pop_item,
  output logic                                               out_valid,
  input  logic                                               out_ready,
  output logic [sixu_pkg::MAX_AXES-1:0][sixu_pkg::UNIT_W-1:0] unit,
  output logic [sixu_pkg::LEN_W-1:0]                         move_length,
  output logic                                               zero_length
);
  import sixu_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SQRT = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t                          state;
  logic [CNT_W-1:0]                cnt;
  logic [MAX_AXES-1:0][MAG_W-1:0]  mag;
  logic [MAX_AXES-1:0]             neg;
  logic [RAD_W-1:0]                rad;
  logic [SQ_REM_W-1:0]             sq_rem;
  logic [LEN_W-1:0]                root;
  logic [MAX_AXES-1:0][LEN_W-1:0]  div_rem;
  logic [MAX_AXES-1:0][QUO_W-1:0]  quo;

  logic [SQ_REM_W-1:0]             rem2;
  logic [SQ_REM_W-1:0]             trial;
  logic                            take;
  logic [SQ_REM_W-1:0]             sq_rem_next;
  logic [LEN_W-1:0]                root_next;
  logic [MAX_AXES-1:0][LEN_W:0]    part;
  logic [MAX_AXES-1:0]             ge;
  logic [MAX_AXES-1:0][LEN_W-1:0]  div_rem_next;
  logic [MAX_AXES-1:0][UNIT_W-1:0] unit_next;
  logic                            load_out;

  // restoring square root, two radicand bits per cycle
  assign rem2  = {sq_rem[SQ_REM_W-3:0], rad[RAD_W-1 -: 2]};
  assign trial = {2'b00, root, 2'b01};
  assign take  = (rem2 >= trial);
  assign sq_rem_next = take ? (rem2 - trial) : rem2;
  assign root_next   = {root[LEN_W-2:0], take};

  always_comb begin
    for (int a = 0; a < MAX_AXES; a++) begin
      // dividend is mag shifted up by 30; the top part is loaded as mag >> 1
      part[a] = {div_rem[a], (cnt == '0) ? mag[a][0] : 1'b0};
      ge[a]   = (part[a] >= {1'b0, root});
      div_rem_next[a] = ge[a] ? LEN_W'(part[a] - {1'b0, root}) : part[a][LEN_W-1:0];
      unit_next[a] = neg[a] ? (~{1'b0, quo[a]} + 1'b1) : {1'b0, quo[a]};
    end
  end

  assign pop_ready = (state == ST_IDLE);
  assign load_out  = (state == ST_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (pop_valid) begin
            state <= ST_SQRT;
            cnt   <= '0;
          end
        end
        ST_SQRT: begin
          if (cnt == CNT_W'(SQRT_STEPS - 1)) begin
            cnt   <= '0;
            state <= (root_next == '0) ? ST_DONE : ST_DIV;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DIV: begin
          if (cnt == CNT_W'(DIV_STEPS - 1)) begin
            cnt   <= '0;
            state <= ST_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DONE: begin
          if (load_out) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && pop_valid) begin
      mag    <= pop_item.mag;
      neg    <= pop_item.neg;
      rad    <= {1'b0, pop_item.sum};
      sq_rem <= '0;
      root   <= '0;
      quo    <= '0;
      for (int a = 0; a < MAX_AXES; a++) begin
        div_rem[a] <= LEN_W'(pop_item.mag[a] >> 1);
      end
    end else if (state == ST_SQRT) begin
      rad    <= {rad[RAD_W-3:0], 2'b00};
      sq_rem <= sq_rem_next;
      root   <= root_next;
    end else if (state == ST_DIV) begin
      div_rem <= div_rem_next;
      for (int a = 0; a < MAX_AXES; a++) begin
        quo[a] <= {quo[a][QUO_W-2:0], ge[a]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      unit        <= unit_next;
      move_length <= root;
      zero_length <= (root == '0);
    end
  end

endmodule

// ----- rtl/six_axis_unit_vector.sv -----
// top level of the six-axis unit vector block
// Takes a target point and a current position (six signed Q15.16 coordinates each) and
// returns the Euclidean move length (unsigned Q18.16, truncated square root) and the six
// direction components in signed Q1.30; a zero-length move gives zero components and
// sets zero_length. The front end takes a request, forms the differences and sums their
// squares with one 32x32 multiplier; a two-entry queue hands the sum to the back end,
// which runs a restoring square root (one root bit per cycle) and then six dividers
// side by side (one quotient bit per cycle). The back end takes a new request only when
// idle, after the previous result has been loaded into the output register, where it
// waits on out_ready; a zero-length move skips the dividers.
// No reset-time clearing is needed.
module six_axis_unit_vector #(
  parameter int AXIS_COUNT = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] goal_x,
  input  logic [31:0] goal_y,
  input  logic [31:0] goal_z,
  input  logic [31:0] goal_a,
  input  logic [31:0] goal_b,
  input  logic [31:0] goal_c,
  input  logic [31:0] pos_x,
  input  logic [31:0] pos_y,
  input  logic [31:0] pos_z,
  input  logic [31:0] pos_a,
  input  logic [31:0] pos_b,
  input  logic [31:0] pos_c,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] unit_x,
  output logic [31:0] unit_y,
  output logic [31:0] unit_z,
  output logic [31:0] unit_a,
  output logic [31:0] unit_b,
  output logic [31:0] unit_c,
  output logic [33:0] move_length,
  output logic        zero_length
);
  import sixu_pkg::*;

  logic [MAX_AXES-1:0][COORD_W-1:0] target;
  logic [MAX_AXES-1:0][COORD_W-1:0] position;
  logic [MAX_AXES-1:0][UNIT_W-1:0]  unit;
  item_t                            push_item;
  item_t                            pop_item;
  logic                             push_valid;
  logic                             push_ready;
  logic                             pop_valid;
  logic                             pop_ready;

  assign target   = {goal_c, goal_b, goal_a, goal_z, goal_y, goal_x};
  assign position = {pos_c, pos_b, pos_a, pos_z, pos_y, pos_x};

  sixu_front #(.AXIS_COUNT(AXIS_COUNT)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .target     (target),
    .position   (position),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  sixu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_item  (push_item),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_item  (pop_item)
  );

  sixu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_item    (pop_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .unit        (unit),
    .move_length (move_length),
    .zero_length (zero_length)
  );

  assign unit_x = unit[0];
  assign unit_y = unit[1];
  assign unit_z = unit[2];
  assign unit_a = unit[3];
  assign unit_b = unit[4];
  assign unit_c = unit[5];

  // zero-length result carries all-zero components
  a_zero_units: assert property (@(posedge clk) disable iff (rst)
    (out_valid && zero_length) |-> (unit_x == 32'd0 && unit_y == 32'd0 && unit_z == 32'd0 &&
      unit_a == 32'd0 && unit_b == 32'd0 && unit_c == 32'd0 && move_length == 34'd0))
    else $error("nonzero component on zero-length result");

  a_flag_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !zero_length) |-> (move_length != 34'd0))
    else $error("zero length without flag");

  // the x component never exceeds one in magnitude
  a_unit_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(unit_x) <= 32'sd1073741824 && $signed(unit_x) >= -32'sd1073741824))
    else $error("unit component out of range");

endmodule

// ----- tb/sv/six_axis_unit_vector_test.sv -----
// testbench for the six-axis unit vector block: self-predicting, random stalls on both sides
`timescale 1ns / 1ps

module six_axis_unit_vector_test;

  localparam int AXES       = 6;
  localparam int ITEM_LAT   = 90;

  typedef struct {
    logic [31:0] unit [AXES];
    logic [33:0] length;
    logic        zero;
  } direction_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] tgt [AXES];
  logic [31:0] pos [AXES];
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] unit_x, unit_y, unit_z, unit_a, unit_b, unit_c;
  logic [33:0] move_length;
  logic        zero_length;

  direction_t expected_dirs [$];
  int         mismatches = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         hold_off_cycles = 0;

  initial begin
    for (int i = 0; i < AXES; i++) begin
      tgt[i] = '0;
      pos[i] = '0;
    end
  end

  six_axis_unit_vector u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .goal_x(tgt[0]), .goal_y(tgt[1]), .goal_z(tgt[2]),
    .goal_a(tgt[3]), .goal_b(tgt[4]), .goal_c(tgt[5]),
    .pos_x(pos[0]), .pos_y(pos[1]), .pos_z(pos[2]),
    .pos_a(pos[3]), .pos_b(pos[4]), .pos_c(pos[5]),
    .out_valid(out_valid), .out_ready(out_ready),
    .unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z),
    .unit_a(unit_a), .unit_b(unit_b), .unit_c(unit_c),
    .move_length(move_length), .zero_length(zero_length)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic direction_t predict_direction(logic [31:0] t [AXES], logic [31:0] p [AXES]);
    direction_t       r;
    logic signed [32:0] d [AXES];
    logic [31:0]      m [AXES];
    logic [67:0]      sum;
    logic [33:0]      root;
    logic [33:0]      cand;
    logic [62:0]      quo;
    sum = '0;
    for (int i = 0; i < AXES; i++) begin
      d[i] = $signed({t[i][31], t[i]}) - $signed({p[i][31], p[i]});
      m[i] = d[i] < 0 ? 32'(-d[i]) : 32'(d[i]);
      sum += 68'(m[i]) * 68'(m[i]);
    end
    root = '0;
    for (int b = 33; b >= 0; b--) begin
      cand = root | (34'd1 << b);
      if (68'(cand) * 68'(cand) <= sum) root = cand;
    end
    for (int i = 0; i < AXES; i++) begin
      quo = (root == 0) ? '0 : ({31'd0, m[i]} << 30) / 63'(root);
      r.unit[i] = d[i] < 0 ? 32'(-quo) : 32'(quo);
    end
    r.length = root;
    r.zero = (root == 0);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [33:0] got, logic [33:0] want);
    mismatches++;
    $display("mismatch %s: got %h want %h", what, got, want);
  endtask

  // one request: idle gap, then hold valid until accepted
  task automatic send_move(logic [31:0] t [AXES], logic [31:0] p [AXES]);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    expected_dirs.push_back(predict_direction(t, p));
    for (int i = 0; i < AXES; i++) begin
      tgt[i] <= t[i];
      pos[i] <= p[i];
    end
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    direction_t e;
    logic [31:0] got [AXES];
    if (!rst && out_valid && out_ready) begin
      got = '{unit_x, unit_y, unit_z, unit_a, unit_b, unit_c};
      if (expected_dirs.size() == 0) begin
        report_mismatch("unexpected result", move_length, '0);
      end else begin
        e = expected_dirs.pop_front();
        for (int i = 0; i < AXES; i++)
          if (got[i] !== e.unit[i])
            report_mismatch($sformatf("unit[%0d]", i), 34'(got[i]), 34'(e.unit[i]));
        if (move_length !== e.length) report_mismatch("move_length", move_length, e.length);
        if (zero_length !== e.zero)
          report_mismatch("zero_length", 34'(zero_length), 34'(e.zero));
      end
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(255) - 128;
      3: return 32'($urandom_range(2000000)) - 32'd1000000;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] t [AXES];
    logic [31:0] p [AXES];
    // zero length, both at origin and at an equal nonzero point
    t = '{default: 0}; p = '{default: 0}; send_move(t, p);
    t = '{default: 32'h1234_5678}; p = t; send_move(t, p);
    // full-range differences, both signs, all axes together
    t = '{default: 32'h7fff_ffff}; p = '{default: 32'h8000_0000}; send_move(t, p);
    send_move(p, t);
    // one axis at a time, either sign, extreme and tiny
    for (int a = 0; a < AXES; a++) begin
      t = '{default: 0}; p = '{default: 0};
      t[a] = 32'h7fff_ffff; p[a] = 32'h8000_0000;
      send_move(t, p);
      t[a] = 32'h0000_0000; p[a] = 32'h0000_0001;
      send_move(t, p);
    end
    t = '{default: 32'hffff_ffff}; p = '{default: 0}; send_move(t, p);
    t = '{default: 32'h0001_0000}; p = '{default: 0}; send_move(t, p);
  endtask

  task automatic test_random(int count, int idle, int stall);
    logic [31:0] t [AXES];
    logic [31:0] p [AXES];
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (count) begin
      for (int i = 0; i < AXES; i++) begin
        t[i] = rand_coord();
        p[i] = ($urandom_range(7) == 0) ? t[i] : rand_coord();
      end
      send_move(t, p);
    end
  endtask

  task automatic test_backpressure();
    logic [31:0] t [AXES];
    logic [31:0] p [AXES];
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 600;
    repeat (8) begin
      for (int i = 0; i < AXES; i++) begin
        t[i] = $urandom;
        p[i] = $urandom;
      end
      send_move(t, p);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(180, 0, 0);
    test_random(180, 72, 0);
    test_random(180, 0, 72);
    test_random(180, 15, 15);
    test_backpressure();
    in_valid <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (expected_dirs.size() != 0) @(posedge clk);
    repeat (ITEM_LAT) @(posedge clk);
    if (mismatches == 0) begin
      $display("six_axis_unit_vector_test OK");
    end else begin
      $display("six_axis_unit_vector_test NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("six_axis_unit_vector_test NOT OK");
    $finish;
  end

endmodule
